### design/magnitude_phase_unwrap_core_defines.svh
// Assertion macros for the magnitude and phase core.
`ifndef MAGNITUDE_PHASE_UNWRAP_CORE_DEFINES_SVH
`define MAGNITUDE_PHASE_UNWRAP_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define MPU_ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);
`define MPU_ASSERT(lbl, prop, msg) \
   `MPU_ASSERT_CLK(lbl, clock, reset, prop, msg)
`else
`define MPU_ASSERT_CLK(lbl, clk, rst, prop, msg)
`define MPU_ASSERT(lbl, prop, msg)
`endif

`endif

### design/mpu_pkg.sv
package mpu_pkg;

   localparam int SAMPLE_WIDTH_DEF    = 16;
   localparam int CORDIC_STAGES_DEF   = 16;
   localparam int PHASE_ACC_WIDTH_DEF = 32;

   // operand fraction bits and angle register width (pi = 2^31 inside the chain)
   localparam int GUARD_BITS  = 24;
   localparam int Z_WIDTH     = 34;
   localparam int ANGLE_SHIFT = 16;

   localparam int PHASE_WIDTH = 17;
   localparam logic signed [PHASE_WIDTH-1:0] PHASE_PI      = 17'sd32768;
   localparam logic signed [PHASE_WIDTH-1:0] PHASE_HALF_PI = 17'sd16384;
   localparam logic signed [Z_WIDTH-1:0]     Z_QUARTER     = 34'sd1073741824;

   // atan(2^-i), pi = 2^31
   localparam logic [31:0] MPU_ATAN [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001, 32'h00000000
   };

   typedef struct packed {
      logic                          valid;
      logic                          first;
      logic                          axis;
      logic signed [PHASE_WIDTH-1:0] axis_phase;
   } mpu_tag_type;

endpackage

### design/mpu_front.sv
module mpu_front #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int XY_WIDTH     = 42,
   parameter int RAD_WIDTH    = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic                              req_valid,
   input  logic [SAMPLE_WIDTH-1:0]           req_re,
   input  logic [SAMPLE_WIDTH-1:0]           req_im,
   input  logic                              req_first,
   output mpu_pkg::mpu_tag_type              tag_o,
   output logic signed [XY_WIDTH-1:0]        x_o,
   output logic signed [XY_WIDTH-1:0]        y_o,
   output logic signed [mpu_pkg::Z_WIDTH-1:0] z_o,
   output logic [RAD_WIDTH-1:0]              rad_o
);
   import mpu_pkg::*;

   logic [SAMPLE_WIDTH-1:0] abs_re, abs_im;
   logic signed [SAMPLE_WIDTH+GUARD_BITS-1:0] re_scaled, im_scaled;
   logic signed [XY_WIDTH-1:0] x_raw, y_raw;

   mpu_tag_type s1_tag_in, s1_tag_ff, s2_tag_ff;
   logic [RAD_WIDTH-1:0] s1_sq_re_in, s1_sq_re_ff, s1_sq_im_in, s1_sq_im_ff, s2_rad_ff;
   logic signed [XY_WIDTH-1:0] s1_x_in, s1_x_ff, s1_y_in, s1_y_ff, s2_x_ff, s2_y_ff;
   logic signed [Z_WIDTH-1:0] s1_z_in, s1_z_ff, s2_z_ff;

   always_comb begin
      abs_re = req_re[SAMPLE_WIDTH-1] ? (~req_re + 1'b1) : req_re;
      abs_im = req_im[SAMPLE_WIDTH-1] ? (~req_im + 1'b1) : req_im;
      s1_sq_re_in = {{(RAD_WIDTH-SAMPLE_WIDTH){1'b0}}, abs_re}
                  * {{(RAD_WIDTH-SAMPLE_WIDTH){1'b0}}, abs_re};
      s1_sq_im_in = {{(RAD_WIDTH-SAMPLE_WIDTH){1'b0}}, abs_im}
                  * {{(RAD_WIDTH-SAMPLE_WIDTH){1'b0}}, abs_im};

      re_scaled = {req_re, {GUARD_BITS{1'b0}}};
      im_scaled = {req_im, {GUARD_BITS{1'b0}}};
      x_raw = XY_WIDTH'(re_scaled);
      y_raw = XY_WIDTH'(im_scaled);

      // left half-plane: rotate by a quarter turn into the right half
      if (x_raw < 0) begin
         if (y_raw >= 0) begin
            s1_x_in = y_raw;
            s1_y_in = -x_raw;
            s1_z_in = Z_QUARTER;
         end else begin
            s1_x_in = -y_raw;
            s1_y_in = x_raw;
            s1_z_in = -Z_QUARTER;
         end
      end else begin
         s1_x_in = x_raw;
         s1_y_in = y_raw;
         s1_z_in = '0;
      end

      s1_tag_in.valid = req_valid;
      s1_tag_in.first = req_first;
      s1_tag_in.axis  = (req_im == '0) || (req_re == '0);
      if (req_im == '0) begin
         s1_tag_in.axis_phase = req_re[SAMPLE_WIDTH-1] ? PHASE_PI : '0;
      end else begin
         s1_tag_in.axis_phase = req_im[SAMPLE_WIDTH-1] ? -PHASE_HALF_PI : PHASE_HALF_PI;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_tag_ff.valid <= 1'b0;
         s2_tag_ff.valid <= 1'b0;
      end else if (advance) begin
         s1_tag_ff <= s1_tag_in;
         s2_tag_ff <= s1_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_sq_re_ff <= s1_sq_re_in;
         s1_sq_im_ff <= s1_sq_im_in;
         s1_x_ff     <= s1_x_in;
         s1_y_ff     <= s1_y_in;
         s1_z_ff     <= s1_z_in;
         s2_rad_ff   <= s1_sq_re_ff + s1_sq_im_ff;
         s2_x_ff     <= s1_x_ff;
         s2_y_ff     <= s1_y_ff;
         s2_z_ff     <= s1_z_ff;
      end
   end

   assign tag_o = s2_tag_ff;
   assign x_o   = s2_x_ff;
   assign y_o   = s2_y_ff;
   assign z_o   = s2_z_ff;
   assign rad_o = s2_rad_ff;

endmodule

### design/mpu_cell.sv
module mpu_cell #(
   parameter int INDEX         = 0,
   parameter int SAMPLE_WIDTH  = 16,
   parameter int CORDIC_STAGES = 16,
   parameter int XY_WIDTH      = 42,
   parameter int RAD_WIDTH     = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,
   input  mpu_pkg::mpu_tag_type               tag_i,
   input  logic signed [XY_WIDTH-1:0]         x_i,
   input  logic signed [XY_WIDTH-1:0]         y_i,
   input  logic signed [mpu_pkg::Z_WIDTH-1:0] z_i,
   input  logic [RAD_WIDTH-1:0]               rad_i,
   input  logic [RAD_WIDTH-1:0]               root_i,
   output mpu_pkg::mpu_tag_type               tag_o,
   output logic signed [XY_WIDTH-1:0]         x_o,
   output logic signed [XY_WIDTH-1:0]         y_o,
   output logic signed [mpu_pkg::Z_WIDTH-1:0] z_o,
   output logic [RAD_WIDTH-1:0]               rad_o,
   output logic [RAD_WIDTH-1:0]               root_o
);
   import mpu_pkg::*;

   localparam bit CORDIC_ACTIVE = INDEX < CORDIC_STAGES;
   localparam bit SQRT_ACTIVE   = INDEX < SAMPLE_WIDTH;
   localparam logic [4:0] ATAN_IDX = 5'(INDEX);
   localparam logic signed [Z_WIDTH-1:0] ATAN_STEP =
      {{(Z_WIDTH-32){1'b0}}, MPU_ATAN[ATAN_IDX]};
   localparam int SQ_SHIFT = SQRT_ACTIVE ? 2 * (SAMPLE_WIDTH - 1 - INDEX) : 0;
   localparam logic [RAD_WIDTH-1:0] SQ_BIT = {{(RAD_WIDTH-1){1'b0}}, 1'b1} << SQ_SHIFT;

   mpu_tag_type tag_ff;
   logic signed [XY_WIDTH-1:0] x_in, x_ff, y_in, y_ff, dx, dy;
   logic signed [Z_WIDTH-1:0] z_in, z_ff;
   logic [RAD_WIDTH-1:0] rad_in, rad_ff, root_in, root_ff;
   logic [RAD_WIDTH:0] trial, wide_rad;

   always_comb begin
      dx = y_i >>> INDEX;
      dy = x_i >>> INDEX;
      if (!CORDIC_ACTIVE) begin
         x_in = x_i;
         y_in = y_i;
         z_in = z_i;
      end else if (y_i > 0) begin
         x_in = x_i + dx;
         y_in = y_i - dy;
         z_in = z_i + ATAN_STEP;
      end else begin
         x_in = x_i - dx;
         y_in = y_i + dy;
         z_in = z_i - ATAN_STEP;
      end

      // one restoring square-root digit
      trial    = {1'b0, root_i} + {1'b0, SQ_BIT};
      wide_rad = {1'b0, rad_i};
      if (!SQRT_ACTIVE) begin
         rad_in  = rad_i;
         root_in = root_i;
      end else if (wide_rad >= trial) begin
         rad_in  = RAD_WIDTH'(wide_rad - trial);
         root_in = (root_i >> 1) + SQ_BIT;
      end else begin
         rad_in  = rad_i;
         root_in = root_i >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff.valid <= 1'b0;
      end else if (advance) begin
         tag_ff <= tag_i;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         rad_ff  <= rad_in;
         root_ff <= root_in;
      end
   end

   assign tag_o  = tag_ff;
   assign x_o    = x_ff;
   assign y_o    = y_ff;
   assign z_o    = z_ff;
   assign rad_o  = rad_ff;
   assign root_o = root_ff;

endmodule

### design/mpu_unwrap.sv
`include "magnitude_phase_unwrap_core_defines.svh"

module mpu_unwrap #(
   parameter int SAMPLE_WIDTH    = 16,
   parameter int RAD_WIDTH       = 32,
   parameter int PHASE_ACC_WIDTH = 32
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       advance,
   input  mpu_pkg::mpu_tag_type                       tag_i,
   input  logic signed [mpu_pkg::Z_WIDTH-1:0]         z_i,
   input  logic [RAD_WIDTH-1:0]                       rad_i,
   input  logic [RAD_WIDTH-1:0]                       root_i,
   output logic                                       rsp_valid,
   output logic [SAMPLE_WIDTH-1:0]                    rsp_amplitude,
   output logic signed [mpu_pkg::PHASE_WIDTH-1:0]     rsp_wrapped_phase,
   output logic signed [PHASE_ACC_WIDTH-1:0]          rsp_unwrapped_phase,
   output logic                                       rsp_saturated
);
   import mpu_pkg::*;

   localparam int PC_WIDTH = Z_WIDTH - ANGLE_SHIFT;
   localparam logic signed [Z_WIDTH-1:0]  ROUND_HALF = Z_WIDTH'(PHASE_PI);
   localparam logic signed [PC_WIDTH-1:0] P_MAX = PC_WIDTH'(PHASE_PI);
   localparam logic signed [PC_WIDTH-1:0] P_MIN = -P_MAX;
   localparam logic signed [PHASE_ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(PHASE_ACC_WIDTH-1){1'b1}}};
   localparam logic signed [PHASE_ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(PHASE_ACC_WIDTH-1){1'b0}}};
   localparam logic signed [PHASE_ACC_WIDTH:0] SUM_HI = (PHASE_ACC_WIDTH+1)'(ACC_MAX);
   localparam logic signed [PHASE_ACC_WIDTH:0] SUM_LO = (PHASE_ACC_WIDTH+1)'(ACC_MIN);
   localparam logic signed [ANGLE_SHIFT-1:0] STEP_MIN = {1'b1, {(ANGLE_SHIFT-1){1'b0}}};

   // stage A: round the angle, finish the root
   logic signed [Z_WIDTH-1:0] z_round;
   logic signed [PC_WIDTH-1:0] p_coarse;
   logic signed [PHASE_WIDTH-1:0] a_phase_in, a_phase_ff;
   logic [SAMPLE_WIDTH-1:0] a_amp_in, a_amp_ff;
   logic a_valid_ff, a_first_ff;

   always_comb begin
      z_round  = z_i + ROUND_HALF;
      p_coarse = z_round[Z_WIDTH-1:ANGLE_SHIFT];
      if (tag_i.axis) begin
         a_phase_in = tag_i.axis_phase;
      end else if (p_coarse > P_MAX) begin
         a_phase_in = PHASE_PI;
      end else if (p_coarse < P_MIN) begin
         a_phase_in = -PHASE_PI;
      end else begin
         a_phase_in = PHASE_WIDTH'(p_coarse);
      end
      a_amp_in = (rad_i > root_i) ? SAMPLE_WIDTH'(root_i + 1'b1) : SAMPLE_WIDTH'(root_i);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= tag_i.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_first_ff <= tag_i.first;
         a_phase_ff <= a_phase_in;
         a_amp_ff   <= a_amp_in;
      end
   end

   // stage B: unwrap against the previous request's phase
   logic signed [PHASE_WIDTH-1:0] prev_ff;
   logic signed [PHASE_ACC_WIDTH-1:0] acc_in, acc_ff;
   logic have_ff, sat_in, rsp_valid_ff, rsp_sat_ff;
   logic signed [PHASE_WIDTH:0] dp;
   logic signed [ANGLE_SHIFT-1:0] dp_low;
   logic signed [PHASE_WIDTH-1:0] dps;
   logic signed [PHASE_ACC_WIDTH:0] sum;
   logic [SAMPLE_WIDTH-1:0] rsp_amp_ff;
   logic signed [PHASE_WIDTH-1:0] rsp_phase_ff;

   always_comb begin
      dp     = (PHASE_WIDTH+1)'(a_phase_ff) - (PHASE_WIDTH+1)'(prev_ff);
      dp_low = dp[ANGLE_SHIFT-1:0];
      // a step of exactly half a turn keeps the sign of the raw step
      if (dp_low == STEP_MIN && dp > 0) begin
         dps = PHASE_PI;
      end else begin
         dps = PHASE_WIDTH'(dp_low);
      end
      sum = (PHASE_ACC_WIDTH+1)'(acc_ff) + (PHASE_ACC_WIDTH+1)'(dps);
      sat_in = 1'b0;
      if (a_first_ff || !have_ff) begin
         acc_in = PHASE_ACC_WIDTH'(a_phase_ff);
      end else if (sum > SUM_HI) begin
         acc_in = ACC_MAX;
         sat_in = 1'b1;
      end else if (sum < SUM_LO) begin
         acc_in = ACC_MIN;
         sat_in = 1'b1;
      end else begin
         acc_in = PHASE_ACC_WIDTH'(sum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         prev_ff      <= '0;
         acc_ff       <= '0;
         have_ff      <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= a_valid_ff;
         if (a_valid_ff) begin
            prev_ff <= a_phase_ff;
            acc_ff  <= acc_in;
            have_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_amp_ff   <= a_amp_ff;
         rsp_phase_ff <= a_phase_ff;
         rsp_sat_ff   <= sat_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_amplitude       = rsp_amp_ff;
   assign rsp_wrapped_phase   = rsp_phase_ff;
   assign rsp_unwrapped_phase = acc_ff;
   assign rsp_saturated       = rsp_sat_ff;

   `MPU_ASSERT(sat_at_limit, rsp_valid && rsp_saturated |-> acc_ff == ACC_MAX || acc_ff == ACC_MIN, "saturated flag without a clamped accumulator")
   `MPU_ASSERT(phase_in_range, rsp_valid |-> rsp_wrapped_phase <= PHASE_PI && rsp_wrapped_phase >= -PHASE_PI, "wrapped phase out of range")
   `MPU_ASSERT(first_passes, advance && a_valid_ff && a_first_ff |=> !rsp_saturated && rsp_unwrapped_phase == PHASE_ACC_WIDTH'(rsp_wrapped_phase), "series start not passed through")
   `MPU_ASSERT(zero_vector_phase, rsp_valid && rsp_amplitude == '0 |-> rsp_wrapped_phase == '0, "zero vector with non-zero phase")

endmodule

### design/magnitude_phase_unwrap_core.sv
// channel   ports                                        direction
// req       req_valid req_ready req_re req_im req_first  in
// rsp       rsp_valid rsp_ready rsp_amplitude
//           rsp_wrapped_phase rsp_unwrapped_phase
//           rsp_saturated                                out
//
// One request per cycle while no result waits in the output register; the row of
// CORDIC/root cells does one rotation and one root digit per cell.
// The whole pipeline holds while a result waits in the output register.
// Reset is synchronous; it clears stage valid bits and the unwrap state.
module magnitude_phase_unwrap_core #(
   parameter int SAMPLE_WIDTH    = mpu_pkg::SAMPLE_WIDTH_DEF,
   parameter int CORDIC_STAGES   = mpu_pkg::CORDIC_STAGES_DEF,
   parameter int PHASE_ACC_WIDTH = mpu_pkg::PHASE_ACC_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [SAMPLE_WIDTH-1:0]                req_re,
   input  logic [SAMPLE_WIDTH-1:0]                req_im,
   input  logic                                   req_first,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [SAMPLE_WIDTH-1:0]                rsp_amplitude,
   output logic signed [mpu_pkg::PHASE_WIDTH-1:0] rsp_wrapped_phase,
   output logic signed [PHASE_ACC_WIDTH-1:0]      rsp_unwrapped_phase,
   output logic                                   rsp_saturated
);
   import mpu_pkg::*;

   localparam int XY_WIDTH   = SAMPLE_WIDTH + GUARD_BITS + 2;
   localparam int RAD_WIDTH  = 2 * SAMPLE_WIDTH;
   localparam int CELL_COUNT = (CORDIC_STAGES > SAMPLE_WIDTH) ? CORDIC_STAGES : SAMPLE_WIDTH;

   logic advance;

   mpu_tag_type tag_chain [CELL_COUNT+1];
   logic signed [XY_WIDTH-1:0] x_chain [CELL_COUNT+1];
   logic signed [XY_WIDTH-1:0] y_chain [CELL_COUNT+1];
   logic signed [Z_WIDTH-1:0] z_chain [CELL_COUNT+1];
   logic [RAD_WIDTH-1:0] rad_chain [CELL_COUNT+1];
   logic [RAD_WIDTH-1:0] root_chain [CELL_COUNT+1];

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;
   assign root_chain[0] = '0;

   mpu_front #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .XY_WIDTH     (XY_WIDTH),
      .RAD_WIDTH    (RAD_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .req_valid (req_valid),
      .req_re    (req_re),
      .req_im    (req_im),
      .req_first (req_first),
      .tag_o     (tag_chain[0]),
      .x_o       (x_chain[0]),
      .y_o       (y_chain[0]),
      .z_o       (z_chain[0]),
      .rad_o     (rad_chain[0])
   );

   for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
      mpu_cell #(
         .INDEX         (i),
         .SAMPLE_WIDTH  (SAMPLE_WIDTH),
         .CORDIC_STAGES (CORDIC_STAGES),
         .XY_WIDTH      (XY_WIDTH),
         .RAD_WIDTH     (RAD_WIDTH)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .tag_i   (tag_chain[i]),
         .x_i     (x_chain[i]),
         .y_i     (y_chain[i]),
         .z_i     (z_chain[i]),
         .rad_i   (rad_chain[i]),
         .root_i  (root_chain[i]),
         .tag_o   (tag_chain[i+1]),
         .x_o     (x_chain[i+1]),
         .y_o     (y_chain[i+1]),
         .z_o     (z_chain[i+1]),
         .rad_o   (rad_chain[i+1]),
         .root_o  (root_chain[i+1])
      );
   end

   // the last cell's rotation outputs are consumed only for the angle
   mpu_unwrap #(
      .SAMPLE_WIDTH    (SAMPLE_WIDTH),
      .RAD_WIDTH       (RAD_WIDTH),
      .PHASE_ACC_WIDTH (PHASE_ACC_WIDTH)
   ) u_unwrap (
      .clock               (clock),
      .reset               (reset),
      .advance             (advance),
      .tag_i               (tag_chain[CELL_COUNT]),
      .z_i                 (z_chain[CELL_COUNT]),
      .rad_i               (rad_chain[CELL_COUNT]),
      .root_i              (root_chain[CELL_COUNT]),
      .rsp_valid           (rsp_valid),
      .rsp_amplitude       (rsp_amplitude),
      .rsp_wrapped_phase   (rsp_wrapped_phase),
      .rsp_unwrapped_phase (rsp_unwrapped_phase),
      .rsp_saturated       (rsp_saturated)
   );

endmodule

### dv/phase_result_checker.sv
`timescale 1ns / 1ps

module phase_result_checker #(
   parameter int SAMPLE_WIDTH    = mpu_pkg::SAMPLE_WIDTH_DEF,
   parameter int CORDIC_STAGES   = mpu_pkg::CORDIC_STAGES_DEF,
   parameter int PHASE_ACC_WIDTH = mpu_pkg::PHASE_ACC_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_ready,
   input  logic [SAMPLE_WIDTH-1:0]                req_re,
   input  logic [SAMPLE_WIDTH-1:0]                req_im,
   input  logic                                   req_first,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   input  logic [SAMPLE_WIDTH-1:0]                rsp_amplitude,
   input  logic signed [mpu_pkg::PHASE_WIDTH-1:0] rsp_wrapped_phase,
   input  logic signed [PHASE_ACC_WIDTH-1:0]      rsp_unwrapped_phase,
   input  logic                                   rsp_saturated,
   output int                                     pending_count,
   output int                                     mismatch_count
);
   import mpu_pkg::*;

   typedef struct {
      logic [SAMPLE_WIDTH-1:0]           amplitude;
      logic signed [PHASE_WIDTH-1:0]     wrapped_phase;
      logic signed [PHASE_ACC_WIDTH-1:0] unwrapped_phase;
      logic                              saturated;
   } sample_result_type;

   localparam longint PI_UNITS = longint'(PHASE_PI);
   localparam longint SUM_HIGH = (longint'(1) <<< (PHASE_ACC_WIDTH - 1)) - 1;
   localparam longint SUM_LOW  = -SUM_HIGH - 1;

   sample_result_type awaited_results[$];
   sample_result_type want;
   longint         last_phase;
   longint         phase_sum;
   bit             series_open;
   int             errors;
   longint         re_s, im_s, angle, step, wrapped_step, total;
   bit             clamped;

   initial begin
      pending_count  = 0;
      mismatch_count = 0;
      errors         = 0;
   end

   function automatic longint unsigned rounded_root(input longint unsigned n);
      longint unsigned r, rest, probe;
      r     = 0;
      rest  = n;
      probe = longint'(1) << 62;
      while (probe > rest) probe >>= 2;
      while (probe != 0) begin
         if (rest >= r + probe) begin
            rest -= r + probe;
            r = (r >> 1) + probe;
         end else begin
            r >>= 1;
         end
         probe >>= 2;
      end
      return (rest > r) ? r + 1 : r;
   endfunction

   // vectoring rotation, angle held with pi = 2^31 until the final rounding
   function automatic longint cordic_phase(input longint re, input longint im);
      longint x, y, z, t, dx, dy, p;
      if (im == 0) return (re < 0) ? PI_UNITS : 0;
      if (re == 0) return (im > 0) ? longint'(PHASE_HALF_PI) : -longint'(PHASE_HALF_PI);
      x = re <<< GUARD_BITS;
      y = im <<< GUARD_BITS;
      z = 0;
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y;
            y = -t;
            z = longint'(Z_QUARTER);
         end else begin
            x = -y;
            y = t;
            z = -longint'(Z_QUARTER);
         end
      end
      for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x += dx;
            y -= dy;
            z += longint'(MPU_ATAN[i]);
         end else begin
            x -= dx;
            y += dy;
            z -= longint'(MPU_ATAN[i]);
         end
      end
      p = (z + 32768) >>> ANGLE_SHIFT;
      if (p > PI_UNITS) p = PI_UNITS;
      if (p < -PI_UNITS) p = -PI_UNITS;
      return p;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         awaited_results.delete();
         last_phase  = 0;
         phase_sum   = 0;
         series_open = 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            re_s    = longint'($signed(req_re));
            im_s    = longint'($signed(req_im));
            angle   = cordic_phase(re_s, im_s);
            clamped = 1'b0;
            if (req_first || !series_open) begin
               phase_sum = angle;
            end else begin
               step         = angle - last_phase;
               wrapped_step = (step + PI_UNITS) % (2 * PI_UNITS);
               if (wrapped_step < 0) wrapped_step += 2 * PI_UNITS;
               wrapped_step -= PI_UNITS;
               // a half turn reached by a positive step keeps its sign
               if (wrapped_step == -PI_UNITS && step > 0) wrapped_step = PI_UNITS;
               total = phase_sum + wrapped_step;
               if (total > SUM_HIGH) begin
                  total   = SUM_HIGH;
                  clamped = 1'b1;
               end
               if (total < SUM_LOW) begin
                  total   = SUM_LOW;
                  clamped = 1'b1;
               end
               phase_sum = total;
            end
            last_phase  = angle;
            series_open = 1'b1;
            want.amplitude       = SAMPLE_WIDTH'(rounded_root(
               longint'(re_s * re_s) + longint'(im_s * im_s)));
            want.wrapped_phase   = PHASE_WIDTH'(angle);
            want.unwrapped_phase = PHASE_ACC_WIDTH'(phase_sum);
            want.saturated       = clamped;
            awaited_results.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               $error("result with no request outstanding");
               errors++;
            end else begin
               want = awaited_results.pop_front();
               if (rsp_amplitude !== want.amplitude) begin
                  $error("amplitude expected %0d got %0d", want.amplitude, rsp_amplitude);
                  errors++;
               end
               if (rsp_wrapped_phase !== want.wrapped_phase) begin
                  $error("wrapped_phase expected %0d got %0d",
                         want.wrapped_phase, rsp_wrapped_phase);
                  errors++;
               end
               if (rsp_unwrapped_phase !== want.unwrapped_phase) begin
                  $error("unwrapped_phase expected %0d got %0d",
                         want.unwrapped_phase, rsp_unwrapped_phase);
                  errors++;
               end
               if (rsp_saturated !== want.saturated) begin
                  $error("saturated expected %0d got %0d", want.saturated, rsp_saturated);
                  errors++;
               end
            end
         end
      end
      pending_count  <= awaited_results.size();
      mismatch_count <= errors;
   end

endmodule

### dv/tb_magnitude_phase_unwrap_core.sv
`timescale 1ns / 1ps

module tb_magnitude_phase_unwrap_core;
   import mpu_pkg::*;

   localparam int SAMPLE_WIDTH    = SAMPLE_WIDTH_DEF;
   localparam int CORDIC_STAGES   = CORDIC_STAGES_DEF;
   localparam int PHASE_ACC_WIDTH = PHASE_ACC_WIDTH_DEF;

   localparam int RANDOM_REQUESTS = 1400;
   // three points per turn give +/- 2^16 per turn; forty turns each way
   localparam int SPIN_REQUESTS   = 120;
   localparam int HOLD_CYCLES     = 300;
   localparam int DRAIN_CYCLES    = 40;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic [SAMPLE_WIDTH-1:0]           req_re = '0;
   logic [SAMPLE_WIDTH-1:0]           req_im = '0;
   logic                              req_first = 1'b0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic [SAMPLE_WIDTH-1:0]           rsp_amplitude;
   logic signed [PHASE_WIDTH-1:0]     rsp_wrapped_phase;
   logic signed [PHASE_ACC_WIDTH-1:0] rsp_unwrapped_phase;
   logic                              rsp_saturated;

   int pending_count;
   int mismatch_count;
   bit rsp_fast = 1'b0;
   bit rsp_hold = 1'b0;

   magnitude_phase_unwrap_core #(
      .SAMPLE_WIDTH    (SAMPLE_WIDTH),
      .CORDIC_STAGES   (CORDIC_STAGES),
      .PHASE_ACC_WIDTH (PHASE_ACC_WIDTH)
   ) i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_re              (req_re),
      .req_im              (req_im),
      .req_first           (req_first),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_amplitude       (rsp_amplitude),
      .rsp_wrapped_phase   (rsp_wrapped_phase),
      .rsp_unwrapped_phase (rsp_unwrapped_phase),
      .rsp_saturated       (rsp_saturated)
   );

   phase_result_checker #(
      .SAMPLE_WIDTH    (SAMPLE_WIDTH),
      .CORDIC_STAGES   (CORDIC_STAGES),
      .PHASE_ACC_WIDTH (PHASE_ACC_WIDTH)
   ) i_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_re              (req_re),
      .req_im              (req_im),
      .req_first           (req_first),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_amplitude       (rsp_amplitude),
      .rsp_wrapped_phase   (rsp_wrapped_phase),
      .rsp_unwrapped_phase (rsp_unwrapped_phase),
      .rsp_saturated       (rsp_saturated),
      .pending_count       (pending_count),
      .mismatch_count      (mismatch_count)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   // entered and left at a rising edge; valid stays up across back-to-back requests
   task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] re,
                              input logic signed [SAMPLE_WIDTH-1:0] im,
                              input logic first, input int unsigned gap);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_re    <= re;
      req_im    <= im;
      req_first <= first;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic logic [SAMPLE_WIDTH-1:0] draw_part();
      logic [SAMPLE_WIDTH-1:0] v;
      case ($urandom_range(0, 9))
         5:       v = SAMPLE_WIDTH'($urandom_range(0, 6) - 3);
         6:       v = '0;
         7:       v = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
         8:       v = $urandom_range(0, 1) ? {1'b0, {(SAMPLE_WIDTH-1){1'b1}}}
                                           : {1'b1, {(SAMPLE_WIDTH-2){1'b0}}, 1'b1};
         default: v = SAMPLE_WIDTH'($urandom);
      endcase
      return v;
   endfunction

   // rotate through three axis points so the unwrapped phase keeps climbing or falling
   task automatic spin(input bit upward);
      logic signed [SAMPLE_WIDTH-1:0] mag;
      for (int k = 0; k < SPIN_REQUESTS; k++) begin
         mag = SAMPLE_WIDTH'($urandom_range(1, 32767));
         case (k % 3)
            0: send_sample(mag, 0, k == 0, 0);
            1: begin
               if (upward) send_sample(-mag, 0, 1'b0, 0);
               else send_sample(0, -mag, 1'b0, 0);
            end
            default: begin
               if (upward) send_sample(0, -mag, 1'b0, 0);
               else send_sample(-mag, 0, 1'b0, 0);
            end
         endcase
      end
   endtask

   // result side
   initial begin
      int unsigned pause;
      int unsigned mode_left;
      bit          calm;
      mode_left = 0;
      calm      = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold) begin
            rsp_hold = 1'b0;
            pause    = HOLD_CYCLES;
         end else if (rsp_fast || calm) begin
            pause = 0;
         end else begin
            pause = $urandom_range(0, 12);
         end
         if (pause != 0) begin
            rsp_ready <= 1'b0;
            repeat (pause) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (mode_left == 0) begin
            calm      = ($urandom_range(0, 3) == 0);
            mode_left = $urandom_range(10, 60);
         end else begin
            mode_left--;
         end
      end
   end

   // request side and verdict
   initial begin
      int unsigned sent;
      int unsigned run_len;
      bit          steady;
      bit          first_run;
      logic        first_flag;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero vector straight after reset, axes, corners, half-turn steps, restarts
      send_sample(0, 0, 1'b0, $urandom_range(0, 12));
      send_sample(32767, 0, 1'b0, $urandom_range(0, 12));
      send_sample(-32768, 0, 1'b0, $urandom_range(0, 12));
      send_sample(32767, 0, 1'b0, $urandom_range(0, 12));
      send_sample(0, 32767, 1'b0, $urandom_range(0, 12));
      send_sample(0, -32768, 1'b0, $urandom_range(0, 12));
      send_sample(-32768, -32768, 1'b0, $urandom_range(0, 12));
      send_sample(32767, 32767, 1'b0, $urandom_range(0, 12));
      send_sample(-32768, 32767, 1'b0, $urandom_range(0, 12));
      send_sample(32767, -32768, 1'b0, $urandom_range(0, 12));
      send_sample(-32768, -1, 1'b0, $urandom_range(0, 12));
      send_sample(-32768, 1, 1'b0, $urandom_range(0, 12));
      send_sample(-32768, -1, 1'b0, $urandom_range(0, 12));
      send_sample(1, 1, 1'b1, $urandom_range(0, 12));
      send_sample(-1, -1, 1'b0, $urandom_range(0, 12));
      send_sample(1, 0, 1'b0, $urandom_range(0, 12));
      send_sample(-1, 0, 1'b0, $urandom_range(0, 12));
      send_sample(1, -1, 1'b0, $urandom_range(0, 12));
      send_sample(-1, 1, 1'b1, $urandom_range(0, 12));
      send_sample(5, -3, 1'b0, $urandom_range(0, 12));

      rsp_fast = 1'b1;
      spin(1'b1);
      spin(1'b0);
      rsp_fast = 1'b0;

      // opening run is back-to-back against a long result hold-off
      rsp_hold  = 1'b1;
      first_run = 1'b1;
      sent      = 0;
      while (sent < RANDOM_REQUESTS) begin
         run_len   = first_run ? 80 : $urandom_range(1, 40);
         steady    = first_run || ($urandom_range(0, 3) == 0);
         first_run = 1'b0;
         for (int k = 0; k < run_len; k++) begin
            if (k == 0) first_flag = ($urandom_range(0, 7) != 0);
            else first_flag = ($urandom_range(0, 29) == 0);
            send_sample(draw_part(), draw_part(), first_flag,
                        steady ? 0 : $urandom_range(0, 12));
         end
         sent += run_len;
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+design
design/mpu_pkg.sv
design/mpu_front.sv
design/mpu_cell.sv
design/mpu_unwrap.sv
design/magnitude_phase_unwrap_core.sv
dv/phase_result_checker.sv
dv/tb_magnitude_phase_unwrap_core.sv
